// ----- design/isotropic_packet_sampler_unit_assert.svh -----
// Assertion macros for the isotropic packet sampler checker
`ifndef ISOTROPIC_PACKET_SAMPLER_UNIT_ASSERT_SVH
`define ISOTROPIC_PACKET_SAMPLER_UNIT_ASSERT_SVH

// consequent in the next cycle, off while in reset
`define IPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ips checker: property failed");

// consequent in the next cycle, checked during reset as well
`define IPS_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ips checker: property failed");

`endif

// ----- design/ips_pkg.sv -----
// Package: constants, types and helper functions of the isotropic packet sampler
`default_nettype none
package ips_pkg;

    localparam int MT_N = 624;
    localparam int MT_M = 397;
    localparam int MT_AW = $clog2(MT_N);
    localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
    localparam logic [31:0] MT_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] SEED_RESET = 32'd5489;

    localparam int WORDS_PER_ITEM = 12;
    localparam int W_TIME = 1;
    localparam int W_POS_X = 3;
    localparam int W_POS_Y = 5;
    localparam int W_POS_Z = 7;
    localparam int W_COS = 9;
    localparam int W_PHI = 11;

    localparam int OUT_FRAC = 30;
    localparam int OUT_SHL = (OUT_FRAC >= 30) ? OUT_FRAC - 30 : 0;
    localparam int OUT_SHR = (OUT_FRAC < 30) ? 30 - OUT_FRAC : 0;

    localparam int CORDIC_STEPS = 32;
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [31:0] ONE_Q30_32 = 32'sh4000_0000;
    localparam logic signed [65:0] RND_HALF = 66'sh2000_0000;
    localparam logic signed [65:0] ONE_Q30 = 66'sh4000_0000;

    localparam logic [31:0] TURN_ATAN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    typedef enum logic [2:0] {
        T_SEED, T_MUL, T_ADD, T_IDLE, T_READ, T_WB
    } t_twist_state;

    typedef enum logic [1:0] {
        C_IDLE, C_DRAW, C_START, C_CALC
    } t_ctrl_state;

    typedef enum logic [2:0] {
        D_IDLE, D_SQ, D_ARG, D_LOOP, D_FIX, D_MX, D_MY, D_RND
    } t_dir_state;

    typedef struct packed {
        logic        ready;
        logic        valid;
        logic [31:0] word;
    } t_rng_out;

    typedef struct packed {
        logic               done;
        logic signed [31:0] mom_x;
        logic signed [31:0] mom_y;
        logic signed [31:0] mom_z;
    } t_dir_out;

    function automatic logic [31:0] temper(input logic [31:0] w);
        logic [31:0] y;
        y = w;
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & 32'h9D2C_5680);
        y = y ^ ((y << 15) & 32'hEFC6_0000);
        y = y ^ (y >> 18);
        return y;
    endfunction

    function automatic logic signed [31:0] round_clamp(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = (p + RND_HALF) >>> 30;
        if (t > ONE_Q30) begin
            t = ONE_Q30;
        end
        if (t < -ONE_Q30) begin
            t = -ONE_Q30;
        end
        return t[31:0];
    endfunction

    function automatic logic [31:0] scale_out(input logic signed [31:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        if (OUT_FRAC >= 30) begin
            w = w <<< OUT_SHL;
        end else begin
            w = w >>> OUT_SHR;
        end
        return w[31:0];
    endfunction

endpackage
`default_nettype wire

// ----- design/ips_if.sv -----
// Interfaces: request channel and packet result channel
`default_nettype none
interface ips_req_if;
    logic valid;
    logic ready;
    logic request;
    modport source (output valid, output request, input ready);
    modport sink (input valid, input request, output ready);
endinterface

interface ips_pkt_if;
    logic               valid;
    logic               ready;
    logic [31:0]        emit_time;
    logic [31:0]        pos_x;
    logic [31:0]        pos_y;
    logic [31:0]        pos_z;
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    modport source (output valid, output emit_time, output pos_x, output pos_y,
                    output pos_z, output mom_x, output mom_y, output mom_z,
                    input ready);
    modport sink (input valid, input emit_time, input pos_x, input pos_y,
                  input pos_z, input mom_x, input mom_y, input mom_z,
                  output ready);
endinterface
`default_nettype wire

// ----- design/ips_twister.sv -----
// Twister word generator: state memory, seeding sweep and per-word in-place twist
`default_nettype none
module ips_twister
    import ips_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    input  wire logic        i_word_req,
    output t_rng_out         o_rng
);

    logic [31:0] mem [MT_N];

    t_twist_state r_state, n_state;
    logic [31:0] r_seed;
    logic [MT_AW-1:0] r_p;
    logic [31:0] r_prev;
    logic [31:0] r_cur;
    logic [31:0] r_prod;
    logic [31:0] r_rd_next;
    logic [31:0] r_rd_far;

    logic [MT_AW-1:0] a_next;
    logic [MT_AW-1:0] a_far;
    logic             p_last;
    logic [31:0]      init_v;
    logic [31:0]      y_mix;
    logic [31:0]      twist_v;
    logic             w_en;
    logic [MT_AW-1:0] w_addr;
    logic [31:0]      w_data;

    assign p_last = (r_p == MT_AW'(MT_N - 1));
    assign a_next = p_last ? '0 : r_p + 1'b1;
    assign a_far  = (r_p >= MT_AW'(MT_N - MT_M)) ? r_p - MT_AW'(MT_N - MT_M)
                                                  : r_p + MT_AW'(MT_M);
    assign init_v = r_prod + 32'(r_p);
    assign y_mix  = {r_cur[31], r_rd_next[30:0]};
    assign twist_v = r_rd_far ^ (y_mix >> 1) ^ (y_mix[0] ? MT_MATRIX : 32'h0);

    always_comb begin
        n_state = r_state;
        if (i_cfg_we) begin
            n_state = T_SEED;
        end else begin
            unique case (r_state)
                T_SEED: n_state = T_MUL;
                T_MUL:  n_state = T_ADD;
                T_ADD:  n_state = p_last ? T_IDLE : T_MUL;
                T_IDLE: n_state = i_word_req ? T_READ : T_IDLE;
                T_READ: n_state = T_WB;
                T_WB:   n_state = i_word_req ? T_READ : T_IDLE;
                default: n_state = T_SEED;
            endcase
        end
    end

    always_comb begin
        w_en   = 1'b0;
        w_addr = r_p;
        w_data = twist_v;
        o_rng.ready = (r_state == T_IDLE);
        o_rng.valid = (r_state == T_WB);
        o_rng.word  = temper(twist_v);
        unique case (r_state)
            T_SEED: begin
                w_en   = 1'b1;
                w_addr = '0;
                w_data = r_seed;
            end
            T_ADD: begin
                w_en   = 1'b1;
                w_data = init_v;
            end
            T_WB: begin
                w_en = 1'b1;
            end
            default: begin
                w_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_SEED;
            r_seed  <= SEED_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_seed <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            T_SEED: begin
                r_p    <= MT_AW'(1);
                r_prev <= r_seed;
                r_cur  <= r_seed;
            end
            T_MUL: begin
                r_prod <= MT_INIT_MUL * (r_prev ^ (r_prev >> 30));
            end
            T_ADD: begin
                r_prev <= init_v;
                r_p    <= p_last ? '0 : r_p + 1'b1;
            end
            T_WB: begin
                r_cur <= r_rd_next;
                r_p   <= a_next;
            end
            default: begin
                r_p <= r_p;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rd_next <= mem[a_next];
        r_rd_far  <= mem[a_far];
    end

endmodule
`default_nettype wire

// ----- design/ips_dir.sv -----
// Direction unit: polar cosine, iterative square root, CORDIC and output scaling
`default_nettype none
module ips_dir
    import ips_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [31:0] i_u_cos,
    input  wire logic [31:0] i_u_phi,
    input  wire logic        i_ack,
    output t_dir_out         o_dir
);

    t_dir_state r_state, n_state;
    logic signed [31:0]   r_cth;
    logic [60:0]          r_sq;
    logic [60:0]          r_arg;
    logic [60:0]          r_res;
    logic [60:0]          r_bit;
    logic signed [CW-1:0] r_x;
    logic signed [CW-1:0] r_y;
    logic signed [CW-1:0] r_z;
    logic [1:0]           r_q;
    logic [4:0]           r_cnt;
    logic signed [CW-1:0] r_cph;
    logic signed [CW-1:0] r_sph;
    logic signed [65:0]   r_px;
    logic signed [65:0]   r_py;
    logic signed [31:0]   r_mom_x;
    logic signed [31:0]   r_mom_y;
    logic signed [31:0]   r_mom_z;
    logic                 r_done;

    logic [1:0]           q_in;
    logic [31:0]          z_in;
    logic signed [63:0]   sq_full;
    logic [61:0]          trial;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] ang;
    logic signed [31:0]   sth;
    logic                 loop_end;

    assign q_in     = 2'((i_u_phi + 32'h2000_0000) >> 30);
    assign z_in     = i_u_phi - {q_in, 30'b0};
    assign sq_full  = 64'(r_cth) * 64'(r_cth);
    assign trial    = {1'b0, r_res} + {1'b0, r_bit};
    assign dx       = r_y >>> r_cnt;
    assign dy       = r_x >>> r_cnt;
    assign ang      = CW'(TURN_ATAN[r_cnt]);
    assign sth      = {1'b0, r_res[30:0]};
    assign loop_end = (r_cnt == 5'(CORDIC_STEPS - 1));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            D_IDLE: n_state = i_start ? D_SQ : D_IDLE;
            D_SQ:   n_state = D_ARG;
            D_ARG:  n_state = D_LOOP;
            D_LOOP: n_state = loop_end ? D_FIX : D_LOOP;
            D_FIX:  n_state = D_MX;
            D_MX:   n_state = D_MY;
            D_MY:   n_state = D_RND;
            D_RND:  n_state = D_IDLE;
            default: n_state = D_IDLE;
        endcase
    end

    always_comb begin
        o_dir.done  = r_done;
        o_dir.mom_x = r_mom_x;
        o_dir.mom_y = r_mom_y;
        o_dir.mom_z = r_mom_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == D_RND) begin
                r_done <= 1'b1;
            end else if (i_ack) begin
                r_done <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            D_IDLE: begin
                r_cth <= $signed({1'b0, i_u_cos[31:1]}) - ONE_Q30_32;
                r_q   <= q_in;
                r_z   <= CW'($signed(z_in));
                r_x   <= CORDIC_GAIN;
                r_y   <= '0;
                r_cnt <= '0;
            end
            D_SQ: begin
                r_sq <= sq_full[60:0];
            end
            D_ARG: begin
                r_arg <= (61'(1) << 60) - r_sq;
                r_res <= '0;
                r_bit <= 61'(1) << 60;
            end
            D_LOOP: begin
                if (r_bit != '0) begin
                    if ({1'b0, r_arg} >= trial) begin
                        r_arg <= r_arg - trial[60:0];
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
                if (!r_z[CW-1]) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - ang;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + ang;
                end
                r_cnt <= r_cnt + 1'b1;
            end
            D_FIX: begin
                unique case (r_q)
                    2'd1: begin
                        r_cph <= -r_y;
                        r_sph <= r_x;
                    end
                    2'd2: begin
                        r_cph <= -r_x;
                        r_sph <= -r_y;
                    end
                    2'd3: begin
                        r_cph <= r_y;
                        r_sph <= -r_x;
                    end
                    default: begin
                        r_cph <= r_x;
                        r_sph <= r_y;
                    end
                endcase
            end
            D_MX: begin
                r_px <= 66'(sth) * 66'(r_cph);
            end
            D_MY: begin
                r_py <= 66'(sth) * 66'(r_sph);
            end
            D_RND: begin
                r_mom_x <= scale_out(round_clamp(r_px));
                r_mom_y <= scale_out(round_clamp(r_py));
                r_mom_z <= scale_out(r_cth);
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

endmodule
`default_nettype wire

// ----- design/isotropic_packet_sampler_unit.sv -----
// Top level of the isotropic packet sampler
//
// Channels: i_req carries one request bit per item; an item with request 1
// yields one packet on o_pkt (time, position, unit direction), an item with
// request 0 is dropped without a result. i_cfg_we/i_cfg_wdata write the seed.
// Each packet: o_pkt.valid rises in the same cycle as i_req.ready, so the
// block takes no new request before it is through with the last one.
// Twelve words are drawn from the state memory (each by a read, then a
// twist and write back); the direction unit then runs a 32-step square
// root and CORDIC loop followed by two multiplies.
// Reset and seed writes run a seeding sweep over the state memory;
// i_req.ready stays low during it.
// The packet sits in an output register: while the receiver stalls the
// block still finishes the next packet and then waits with it.
`default_nettype none
module isotropic_packet_sampler_unit
    import ips_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [31:0] i_cfg_wdata,
    ips_req_if.sink          i_req,
    ips_pkt_if.source        o_pkt
);

    t_ctrl_state r_ctrl, n_ctrl;
    logic [3:0]  r_wcnt;
    logic [31:0] r_time;
    logic [31:0] r_px;
    logic [31:0] r_py;
    logic [31:0] r_pz;
    logic [31:0] r_ucos;
    logic [31:0] r_uphi;
    logic        r_ovalid;
    logic [31:0] r_otime;
    logic [31:0] r_ox;
    logic [31:0] r_oy;
    logic [31:0] r_oz;
    logic signed [31:0] r_omx;
    logic signed [31:0] r_omy;
    logic signed [31:0] r_omz;

    t_rng_out rng;
    t_dir_out dir;
    logic word_req;
    logic dir_start;
    logic out_load;
    logic out_free;
    logic in_take;
    logic last_word;

    ips_twister u_twister (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_word_req  (word_req),
        .o_rng       (rng)
    );

    ips_dir u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dir_start),
        .i_u_cos (r_ucos),
        .i_u_phi (r_uphi),
        .i_ack   (out_load),
        .o_dir   (dir)
    );

    assign last_word = rng.valid && (r_wcnt == 4'(WORDS_PER_ITEM - 1));
    assign out_free  = !r_ovalid || o_pkt.ready;

    always_comb begin
        n_ctrl = r_ctrl;
        unique case (r_ctrl)
            C_IDLE:  n_ctrl = (in_take && i_req.request) ? C_DRAW : C_IDLE;
            C_DRAW:  n_ctrl = last_word ? C_START : C_DRAW;
            C_START: n_ctrl = C_CALC;
            C_CALC:  n_ctrl = (dir.done && out_free) ? C_IDLE : C_CALC;
            default: n_ctrl = C_IDLE;
        endcase
    end

    always_comb begin
        i_req.ready = (r_ctrl == C_IDLE) && rng.ready;
        in_take     = i_req.valid && i_req.ready;
        word_req    = (r_ctrl == C_DRAW) &&
                      (({1'b0, r_wcnt} + 5'(rng.valid)) < 5'(WORDS_PER_ITEM));
        dir_start   = (r_ctrl == C_START);
        out_load    = (r_ctrl == C_CALC) && dir.done && out_free;
        o_pkt.valid     = r_ovalid;
        o_pkt.emit_time = r_otime;
        o_pkt.pos_x     = r_ox;
        o_pkt.pos_y     = r_oy;
        o_pkt.pos_z     = r_oz;
        o_pkt.mom_x     = r_omx;
        o_pkt.mom_y     = r_omy;
        o_pkt.mom_z     = r_omz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl   <= C_IDLE;
            r_wcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_ctrl <= n_ctrl;
            if (r_ctrl == C_IDLE) begin
                r_wcnt <= '0;
            end else if (rng.valid) begin
                r_wcnt <= r_wcnt + 1'b1;
            end
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (o_pkt.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rng.valid && (r_ctrl == C_DRAW)) begin
            unique case (r_wcnt)
                4'(W_TIME):  r_time <= rng.word;
                4'(W_POS_X): r_px   <= rng.word;
                4'(W_POS_Y): r_py   <= rng.word;
                4'(W_POS_Z): r_pz   <= rng.word;
                4'(W_COS):   r_ucos <= rng.word;
                4'(W_PHI):   r_uphi <= rng.word;
                default:     r_time <= r_time;
            endcase
        end
        if (out_load) begin
            r_otime <= r_time;
            r_ox    <= r_px;
            r_oy    <= r_py;
            r_oz    <= r_pz;
            r_omx   <= dir.mom_x;
            r_omy   <= dir.mom_y;
            r_omz   <= dir.mom_z;
        end
    end

endmodule
`default_nettype wire

// ----- design/ips_checker.sv -----
// Port-level checker for the isotropic packet sampler, with its bind
`default_nettype none
`include "isotropic_packet_sampler_unit_assert.svh"
module ips_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_cfg_we,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_in_request,
    input wire logic i_out_valid,
    input wire logic i_out_ready
);

    `IPS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)
    `IPS_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_in_valid && i_in_ready && i_in_request, !i_in_ready)
    `IPS_ASSERT_NEXT(a_seed_sweep, i_clk, i_rst_n, i_cfg_we, !i_in_ready)
    `IPS_ASSERT_ALWAYS_NEXT(a_reset_sweep, i_clk, !i_rst_n, !i_in_ready)

endmodule

bind isotropic_packet_sampler_unit ips_checker u_ips_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_cfg_we     (i_cfg_we),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_in_request (i_req.request),
    .i_out_valid  (o_pkt.valid),
    .i_out_ready  (o_pkt.ready)
);
`default_nettype wire
